>>> rtl/smme_pkg.sv
// ----------------------------------------------------------------------------
// smme_pkg
// shared types and constants for the square-and-multiply trace block
// ----------------------------------------------------------------------------
package smme_pkg;

    localparam int unsigned FIELD_W = 32;
    localparam int unsigned ROW_W   = 5;

    // job handed from the front part to the back part
    typedef struct packed {
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] expo;
        logic [FIELD_W-1:0] modulus;
        logic [5:0]         top;
        logic               empty;
    } t_job;

endpackage

>>> rtl/square_multiply_modexp_trace.sv
// ----------------------------------------------------------------------------
// square_multiply_modexp_trace
// left-to-right square-and-multiply modular exponentiation with row trace
// ----------------------------------------------------------------------------
// Each input word (base, exponent, modulus) yields one output word per exponent
// bit from the top set bit down to bit 0, or a single empty row for a zero
// exponent. A front queue of two words takes input while the back part works.
// Every modular product goes through one shared bit-serial reducer of 64
// remainder steps (skipped for a zero modulus). The first row takes only the
// initial base reduction; each later row takes a square, plus a multiply
// when its exponent bit is set.
module square_multiply_modexp_trace import smme_pkg::*; #(
    parameter int unsigned EXP_WIDTH = 32,
    parameter int unsigned MOD_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // base_value [31:0], exponent_value [63:32], modulus_value [95:64]
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // exponent_bit [0], square_result [32:1], multiply_result [64:33],
    // row_index [69:65], zero fill [71:70]
    output logic [71:0]  m_axis_tdata,
    // empty_flag
    output logic         m_axis_tuser,
    // last_row
    output logic         m_axis_tlast
);
    logic               w_jv;
    logic               w_take;
    t_job               w_job;
    logic               w_bit;
    logic [FIELD_W-1:0] w_sq;
    logic [FIELD_W-1:0] w_val;
    logic [ROW_W-1:0]   w_row;

    smme_front #(.EXP_WIDTH(EXP_WIDTH), .MOD_WIDTH(MOD_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_base(s_axis_tdata[31:0]), .i_expo(s_axis_tdata[63:32]),
        .i_modulus(s_axis_tdata[95:64]),
        .o_job_valid(w_jv), .i_job_take(w_take), .o_job(w_job)
    );

    smme_back #(.MOD_WIDTH(MOD_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(w_jv), .o_job_take(w_take), .i_job(w_job),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_bit(w_bit), .o_sq(w_sq), .o_val(w_val), .o_row(w_row),
        .o_empty(m_axis_tuser), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_row, w_val, w_sq, w_bit};
endmodule

>>> rtl/smme_front.sv
// ----------------------------------------------------------------------------
// smme_front
// accepts input words, masks fields, finds the top set bit, queues jobs
// ----------------------------------------------------------------------------
module smme_front import smme_pkg::*; #(
    parameter int unsigned EXP_WIDTH = 32,
    parameter int unsigned MOD_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [FIELD_W-1:0]   i_base,
    input  logic [FIELD_W-1:0]   i_expo,
    input  logic [FIELD_W-1:0]   i_modulus,
    output logic                 o_job_valid,
    input  logic                 i_job_take,
    output t_job                 o_job
);
    localparam int unsigned EW = (EXP_WIDTH < FIELD_W) ? EXP_WIDTH : FIELD_W;

    // two-entry queue
    t_job       r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;

    logic [FIELD_W-1:0] w_expo;
    logic [FIELD_W-1:0] w_mod;
    logic [5:0]         w_top;
    t_job               w_job;
    logic               w_push;

    always_comb begin
        w_expo = i_expo;
        w_mod  = i_modulus;
        for (int k = EW; k < FIELD_W; k++) w_expo[k] = 1'b0;
        for (int k = MOD_WIDTH; k < FIELD_W; k++) w_mod[k] = 1'b0;
        w_top = '0;
        for (int k = 0; k < FIELD_W; k++) begin
            if (w_expo[k]) w_top = 6'(k);
        end
        w_job.base    = i_base;
        w_job.expo    = w_expo;
        w_job.modulus = w_mod;
        w_job.top     = w_top;
        w_job.empty   = (w_expo == '0);
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= w_job;
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (i_job_take && o_job_valid) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_job_take && o_job_valid);
        end
    end
endmodule

>>> rtl/smme_mulmod.sv
// ----------------------------------------------------------------------------
// smme_mulmod
// shared modular multiplier, one restoring remainder bit a cycle
// ----------------------------------------------------------------------------
module smme_mulmod import smme_pkg::*; #(
    parameter int unsigned MOD_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [FIELD_W-1:0] i_a,
    input  logic [FIELD_W-1:0] i_b,
    input  logic [FIELD_W-1:0] i_m,
    output logic               o_done,
    output logic [FIELD_W-1:0] o_r
);
    localparam int unsigned PW = 2 * FIELD_W;

    logic [PW-1:0]      r_prod;
    logic [FIELD_W:0]   r_rem;
    logic [FIELD_W-1:0] r_m;
    logic [6:0]         r_cnt;
    logic               r_busy;
    logic [FIELD_W:0]   w_sh;
    logic [FIELD_W-1:0] w_mask;

    always_comb begin
        w_mask = '0;
        for (int k = 0; k < MOD_WIDTH; k++) w_mask[k] = 1'b1;
        w_sh = {r_rem[FIELD_W-1:0], r_prod[PW-1]};
    end

    assign o_r = r_rem[FIELD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_m    <= i_m;
                r_prod <= PW'(i_a) * PW'(i_b);
                r_rem  <= '0;
                r_cnt  <= 7'(PW);
            end else if (r_busy) begin
                if (r_m == '0) begin
                    // modulus taken as 2^MOD_WIDTH
                    r_rem  <= {1'b0, r_prod[FIELD_W-1:0] & w_mask};
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_prod <= {r_prod[PW-2:0], 1'b0};
                    r_cnt  <= r_cnt - 7'd1;
                    if (w_sh >= {1'b0, r_m}) r_rem <= w_sh - {1'b0, r_m};
                    else                     r_rem <= w_sh;
                end
            end
        end
    end
endmodule

>>> rtl/smme_back.sv
// ----------------------------------------------------------------------------
// smme_back
// sequences square and multiply steps per exponent bit and drives rows
// ----------------------------------------------------------------------------
module smme_back import smme_pkg::*; #(
    parameter int unsigned MOD_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    output logic               o_job_take,
    input  t_job               i_job,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_bit,
    output logic [FIELD_W-1:0] o_sq,
    output logic [FIELD_W-1:0] o_val,
    output logic [ROW_W-1:0]   o_row,
    output logic               o_empty,
    output logic               o_last
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RED  = 6'b000010,
        S_SQ   = 6'b000100,
        S_MUL  = 6'b001000,
        S_OUT  = 6'b010000,
        S_WAIT = 6'b100000
    } t_state;

    t_state             r_st;
    t_job               r_job;
    logic [FIELD_W-1:0] r_b;
    logic [FIELD_W-1:0] r_val;
    logic [FIELD_W-1:0] r_sq;
    logic [5:0]         r_pos;
    logic [ROW_W-1:0]   r_row;
    // launch pulse registered: start in the first cycle of a compute state
    logic               r_go;

    logic               w_start;
    logic [FIELD_W-1:0] w_a;
    logic [FIELD_W-1:0] w_bb;
    logic               w_done;
    logic [FIELD_W-1:0] w_r;
    logic               w_bit;

    assign w_bit = r_job.expo[r_pos[4:0]];

    smme_mulmod #(.MOD_WIDTH(MOD_WIDTH)) u_mm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_a(w_a), .i_b(w_bb), .i_m(r_job.modulus), .o_done(w_done), .o_r(w_r)
    );

    assign o_job_take = (r_st == S_IDLE) && i_job_valid;

    always_comb begin
        w_a     = r_val;
        w_bb    = r_val;
        case (r_st)
            S_IDLE: ;
            S_RED:  begin w_a = r_job.base; w_bb = FIELD_W'(1); end
            S_SQ:   ;
            S_MUL:  begin w_a = r_sq; w_bb = r_b; end
            S_OUT:  ;
            S_WAIT: ;
            default: ;
        endcase
    end

    assign w_start = r_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            o_valid <= 1'b0;
            r_go    <= 1'b0;
        end else begin
            r_go <= 1'b0;
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_pos   <= i_job.top;
                        r_row   <= '0;
                        if (i_job.empty) begin
                            r_st <= S_OUT;
                        end else begin
                            r_st <= S_RED;
                            r_go <= 1'b1;
                        end
                    end
                end
                S_RED: begin
                    if (w_done) begin
                        r_b   <= w_r;
                        r_val <= w_r;
                        r_sq  <= FIELD_W'(1);
                        r_st  <= S_OUT;
                    end
                end
                S_SQ: begin
                    if (w_done) begin
                        r_sq <= w_r;
                        if (w_bit) begin
                            r_st <= S_MUL;
                            r_go <= 1'b1;
                        end else begin
                            r_val <= w_r;
                            r_st  <= S_OUT;
                        end
                    end
                end
                S_MUL: begin
                    if (w_done) begin
                        r_val <= w_r;
                        r_st  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid <= 1'b1;
                        o_empty <= r_job.empty;
                        o_last  <= r_job.empty || (r_pos == '0);
                        o_bit   <= r_job.empty ? 1'b0 : w_bit;
                        o_sq    <= r_job.empty ? '0 : r_sq;
                        o_val   <= r_job.empty ? '0 : r_val;
                        o_row   <= r_job.empty ? '0 : r_row;
                        if (r_job.empty || r_pos == '0) begin
                            r_st <= S_IDLE;
                        end else begin
                            r_pos <= r_pos - 6'd1;
                            r_row <= r_row + ROW_W'(1);
                            r_st  <= S_SQ;
                            r_go  <= 1'b1;
                        end
                    end
                end
                S_WAIT: r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_empty) |-> o_last)
        else $error("empty row without last");
    a_idle_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |-> (r_st == S_IDLE))
        else $error("job taken while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_val) && $stable(o_row)))
        else $error("row changed under stall");
`endif
endmodule

>>> tb/sv/square_multiply_modexp_trace_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_multiply_modexp_trace_tb
// self-checking bench for the modular exponentiation trace block
// ----------------------------------------------------------------------------
// Input words carry base, exponent and modulus. Each accepted word is expanded
// into the row trace it must produce, and every output word is compared
// with the oldest expected row. Both sides idle at random, and once the
// output side holds off for a long stretch so that the input side backs up.
module square_multiply_modexp_trace_tb;
    import smme_pkg::*;

    // one expected output word
    typedef struct packed {
        logic        bit_val;
        logic [31:0] square;
        logic [31:0] product;
        logic [4:0]  row;
        logic        empty;
        logic        last;
    } trace_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // base_value [31:0], exponent_value [63:32], modulus_value [95:64]
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // exponent_bit [0], square_result [32:1], multiply_result [64:33],
    // row_index [69:65], zero fill [71:70]
    logic [71:0] m_axis_tdata;
    // empty_flag
    logic        m_axis_tuser;
    // last_row
    logic        m_axis_tlast;

    logic [95:0] job_queue[$];   // input words not yet offered
    trace_row_t  row_queue[$];   // rows still owed by the block
    int          mismatches;
    int          words_taken;
    int          send_gap;
    int          take_gap;
    int          hold_left;
    bit          hold_done;

    square_multiply_modexp_trace DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // reduction; a zero modulus keeps the low 32 bits
    function automatic longint unsigned reduce_mod(longint unsigned x,
                                                   longint unsigned m);
        if (m == 0) return x & 64'hFFFF_FFFF;
        return x % m;
    endfunction

    // expand one job into its trace rows, products at full 64-bit width
    function automatic void expand_trace(logic [31:0] base, logic [31:0] expo,
                                         logic [31:0] modulus);
        longint unsigned m;
        longint unsigned b;
        longint unsigned acc;
        longint unsigned sq;
        int              top;
        int              pos;
        int              row;
        trace_row_t      r;
        if (expo == 32'd0) begin
            r = '0;
            r.empty = 1'b1;
            r.last = 1'b1;
            row_queue.push_back(r);
            return;
        end
        top = 0;
        for (pos = 0; pos < 32; pos++)
            if (expo[pos]) top = pos;
        m = modulus;
        b = reduce_mod(base, m);
        acc = 0;
        row = 0;
        for (pos = top; pos >= 0; pos--) begin
            if (row == 0) begin
                sq = 1;
                acc = b;
            end else begin
                sq = reduce_mod(acc * acc, m);
                acc = expo[pos] ? reduce_mod(sq * b, m) : sq;
            end
            r.bit_val = expo[pos];
            r.square = sq[31:0];
            r.product = acc[31:0];
            r.row = row[4:0];
            r.empty = 1'b0;
            r.last = (pos == 0);
            row_queue.push_back(r);
            row++;
        end
    endfunction

    task automatic report_mismatch(string what, longint unsigned got,
                                   longint unsigned want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // driver: offers queued words with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            send_gap <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (job_queue.size() > 0) begin
                s_axis_tdata <= job_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // predict on every accepted input word
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expand_trace(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tdata[95:64]);
            words_taken <= words_taken + 1;
        end
    end

    // one long output hold-off, counted here, once the input is flowing
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && words_taken == 40) begin
            hold_left <= 3000;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // output side ready with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            take_gap <= 0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
        end else if (take_gap > 0) begin
            take_gap <= take_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            take_gap <= pick_gap();
        end
    end

    // monitor: compare each output word with the oldest expected row
    always @(posedge i_clk) begin
        trace_row_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (row_queue.size() == 0) begin
                $display("unexpected output word %0h at %0t", m_axis_tdata, $realtime);
                mismatches++;
            end else begin
                want = row_queue.pop_front();
                if (m_axis_tdata[0] !== want.bit_val)
                    report_mismatch("exponent_bit", m_axis_tdata[0], want.bit_val);
                if (m_axis_tdata[32:1] !== want.square)
                    report_mismatch("square_result", m_axis_tdata[32:1], want.square);
                if (m_axis_tdata[64:33] !== want.product)
                    report_mismatch("multiply_result", m_axis_tdata[64:33], want.product);
                if (m_axis_tdata[69:65] !== want.row)
                    report_mismatch("row_index", m_axis_tdata[69:65], want.row);
                if (m_axis_tdata[71:70] !== 2'b00)
                    report_mismatch("zero fill", m_axis_tdata[71:70], 0);
                if (m_axis_tuser !== want.empty)
                    report_mismatch("empty_flag", m_axis_tuser, want.empty);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_row", m_axis_tlast, want.last);
            end
        end
    end

    function automatic logic [31:0] pick_modulus();
        int r;
        r = $urandom_range(99);
        if (r < 40) return $urandom_range(1, 1000);
        if (r < 45) return 32'd1;
        if (r < 50) return 32'hFFFF_FFFF;
        return $urandom | 32'd1 << $urandom_range(31);
    endfunction

    // exponent: mostly short so runs stay quick, some zero, a few full width
    function automatic logic [31:0] pick_exponent();
        int          r;
        int          w;
        logic [31:0] e;
        r = $urandom_range(99);
        if (r < 6) return 32'd0;
        if (r < 12) return $urandom;
        w = $urandom_range(1, 10);
        e = $urandom & ((32'd1 << w) - 1);
        return e;
    endfunction

    function automatic logic [95:0] pack_job(logic [31:0] b, logic [31:0] e,
                                             logic [31:0] m);
        return {m, e, b};
    endfunction

    initial begin
        int i;
        int idle;
        mismatches = 0;
        words_taken = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        // directed: zero exponent, one bit, all ones, top bit alone
        job_queue.push_back(pack_job(32'd7, 32'd0, 32'd13));
        job_queue.push_back(pack_job(32'd5, 32'd1, 32'd13));
        job_queue.push_back(pack_job(32'd3, 32'd2, 32'd1000));
        job_queue.push_back(pack_job(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        job_queue.push_back(pack_job(32'hFFFF_FFFE, 32'h8000_0000, 32'hFFFF_FFFB));
        // modulus of one, base of zero, base wider than modulus
        job_queue.push_back(pack_job(32'd12345, 32'd77, 32'd1));
        job_queue.push_back(pack_job(32'd0, 32'd9, 32'd97));
        job_queue.push_back(pack_job(32'hDEAD_BEEF, 32'd11, 32'd101));
        job_queue.push_back(pack_job(32'h1234_5678, 32'hAAAA_AAAA, 32'h8000_0001));
        job_queue.push_back(pack_job(32'hFFFF_FFFF, 32'd3, 32'd2));
        job_queue.push_back(pack_job(32'd0, 32'd0, 32'hFFFF_FFFF));
        job_queue.push_back(pack_job(32'd2, 32'h0000_FFFF, 32'h7FFF_FFFF));
        job_queue.push_back(pack_job(32'd65537, 32'h5555_5555, 32'hFFFF_FFFF));
        // zero modulus keeps the low 32 bits of each product
        job_queue.push_back(pack_job(32'h8765_4321, 32'd29, 32'd0));
        for (i = 0; i < 260; i++)
            job_queue.push_back(pack_job($urandom, pick_exponent(), pick_modulus()));
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // wait for the whole stimulus to be taken, then for the trace to drain
        while (job_queue.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (row_queue.size() > 0) @(posedge i_clk);
        // idle tail: any stray word in it is caught by the monitor
        for (idle = 0; idle < 300; idle++) @(posedge i_clk);
        if (mismatches == 0 && row_queue.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin
        #40ms;
        $display("FAILURE");
        $finish;
    end

endmodule
